// File: src/fpd_pkg.sv
// Shared constants and the pipeline stage record for the Q16.16 divider.
`default_nettype none
package fpd_pkg;

    // Operand and result width, and the fixed-point split
    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_SHIFT = 14;

    // Quotient magnitude bits produced on the normal path
    localparam int Q_BITS = GUARD_SHIFT + FRAC_BITS;

    // Saturated result codes
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // One item in flight: rem holds the partial remainder, num shifts numerator
    // bits out at the top while quotient bits enter at the bottom.
    typedef struct packed {
        logic              valid;
        logic              sat;
        logic              neg;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [Q_BITS-1:0] num;
    } t_stage;

endpackage
`default_nettype wire

// File: src/fpd_prep.sv
// Entry stage: operand magnitudes, result sign, overflow guard, remainder seed.
`default_nettype none
module fpd_prep
    import fpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output t_stage                 o_stage
);

    logic [DATA_W-1:0] w_ua;
    logic [DATA_W-1:0] w_ub;
    logic              w_sat;
    t_stage            r_stage;

    // Unsigned magnitudes; the most negative value maps to 2^31
    always_comb begin
        w_ua  = i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
        w_ub  = i_divisor[DATA_W-1]  ? (DATA_W'(0) - i_divisor)  : i_divisor;
        // Quotient would not fit (covers a zero divisor)
        w_sat = (w_ua >> GUARD_SHIFT) >= w_ub;
    end

    // Stage register: only the valid bit is reset; top dividend bits seed the
    // remainder, the rest feed the shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= i_valid;
        end
        if (i_en) begin
            r_stage.sat <= w_sat;
            r_stage.neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_stage.den <= w_ub;
            r_stage.rem <= DATA_W'(w_ua[DATA_W-1:GUARD_SHIFT]);
            r_stage.num <= {w_ua[GUARD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

// File: src/fpd_step.sv
// One restoring-division step: shift in a numerator bit, trial subtract, register.
`default_nettype none
module fpd_step
    import fpd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_stage i_stage,
    output t_stage      o_stage
);

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic              w_qbit;
    t_stage            r_stage;

    // Trial subtract; no borrow means the quotient bit is one
    always_comb begin
        w_shift = {i_stage.rem, i_stage.num[Q_BITS-1]};
        w_diff  = w_shift - {1'b0, i_stage.den};
        w_qbit  = ~w_diff[DATA_W];
    end

    // Stage register: only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= i_stage.valid;
        end
        if (i_en) begin
            r_stage.sat <= i_stage.sat;
            r_stage.neg <= i_stage.neg;
            r_stage.den <= i_stage.den;
            r_stage.rem <= w_qbit ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_stage.num <= {i_stage.num[Q_BITS-2:0], w_qbit};
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

// File: src/fpd_post.sv
// Output stage: sign fix-up or saturation code, held in the output register.
`default_nettype none
module fpd_post
    import fpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire t_stage             i_stage,
    output logic                    o_valid,
    output logic [DATA_W-1:0]       o_quotient,
    output logic                    o_saturated
);

    logic [DATA_W-1:0] w_mag;
    logic [DATA_W-1:0] w_res;
    logic              r_valid;
    logic [DATA_W-1:0] r_quotient;
    logic              r_saturated;

    // Truncate toward zero by negating the magnitude
    always_comb begin
        w_mag = DATA_W'(i_stage.num);
        if (i_stage.sat) begin
            w_res = i_stage.neg ? SAT_NEG : SAT_POS;
        end else begin
            w_res = i_stage.neg ? (DATA_W'(0) - w_mag) : w_mag;
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient  <= w_res;
            r_saturated <= i_stage.sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_saturated = r_saturated;

endmodule
`default_nettype wire

// File: src/fixed_point_16_16_divider_core.sv
// Top level of the pipelined signed Q16.16 saturating divider.
`default_nettype none
// Divides two signed Q16.16 operands and returns a Q16.16 quotient truncated
// toward zero, or a saturated code (0x80000000 when the operand signs differ,
// else 0x7FFFFFFF) with tuser set when |dividend| >> 14 >= |divisor|, which
// includes a zero divisor. The pipeline takes one transfer per clock while it
// is not held and has one entry stage, 30 restoring-division stages (one
// quotient bit and one 33-bit trial subtract each) and one output register.
// The whole pipeline advances together; it holds while the output register is
// full and not taken, and s_tready is low only then.
module fixed_point_16_16_divider_core
    import fpd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input stream
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [2*DATA_W-1:0] i_s_tdata,   // [31:0] dividend, [63:32] divisor
    // Result stream
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [DATA_W-1:0]        o_m_tdata,   // [31:0] quotient
    output logic [0:0]               o_m_tuser    // [0] saturated
);

    logic   w_en;
    logic   w_sat;
    t_stage w_pipe [0:Q_BITS];

    // Global advance: output register empty or being taken
    assign w_en       = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = w_en;

    // Entry stage
    fpd_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_tvalid),
        .i_dividend (i_s_tdata[DATA_W-1:0]),
        .i_divisor  (i_s_tdata[2*DATA_W-1:DATA_W]),
        .o_stage    (w_pipe[0])
    );

    // Division steps, one quotient bit per stage
    for (genvar g = 0; g < Q_BITS; g++) begin : g_step
        fpd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_pipe[g]),
            .o_stage (w_pipe[g+1])
        );
    end

    // Output register
    fpd_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_stage     (w_pipe[Q_BITS]),
        .o_valid     (o_m_tvalid),
        .o_quotient  (o_m_tdata),
        .o_saturated (w_sat)
    );

    assign o_m_tuser = w_sat;

`ifndef SYNTHESIS
    // A saturated result carries one of the two saturation codes
    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == SAT_POS || o_m_tdata == SAT_NEG))
        else $error("saturated result without a saturation code");

    // A normal result magnitude stays below 2^30
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[DATA_W-1] == o_m_tdata[DATA_W-2]))
        else $error("normal result out of range");

    // An accepted transfer enters the entry stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_pipe[0].valid)
        else $error("accepted transfer lost at entry stage");
`endif

endmodule
`default_nettype wire
